FILE: src/psw_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the priority scheduler
package psw_pkg;

   localparam int MAX_PROCESSES = 16;

   // count of stored processes, able to hold MAX_PROCESSES itself
   localparam int CNT_W = $clog2(MAX_PROCESSES + 1);
   // index into the process store
   localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
   localparam int NUM_W = 5;
   localparam int EXT_W = (CNT_W > NUM_W) ? CNT_W : NUM_W;

   // running wait and turnaround, never below the 13 bit result fields
   localparam int SUM_RAW_W = $clog2(MAX_PROCESSES * 255 + 1);
   localparam int SUM_W = (SUM_RAW_W > 13) ? SUM_RAW_W : 13;
   // totals over the whole set
   localparam int TOT_RAW_W = $clog2(MAX_PROCESSES * MAX_PROCESSES * 255 + 1);
   localparam int TOT_W = (TOT_RAW_W > 13) ? TOT_RAW_W : 13;
   localparam int DIV_STEP_W = $clog2(TOT_W + 1);

   typedef struct packed {
      logic [7:0] burst_time;
      logic [7:0] priority_level;
      logic       last_process;
   } psw_req_type;

   typedef struct packed {
      logic [4:0]  process_number;
      logic [7:0]  burst_out;
      logic [11:0] waiting_time;
      logic [12:0] turnaround_time;
      logic [11:0] average_waiting;
      logic [12:0] average_turnaround;
      logic        last_result;
   } psw_rsp_type;

   typedef struct packed {
      logic [7:0]       prio;
      logic [7:0]       burst;
      logic [NUM_W-1:0] number;
   } psw_entry_type;

   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] divisor;
      logic [TOT_W-1:0] dividend_a;
      logic [TOT_W-1:0] dividend_b;
   } psw_div_req_type;

   typedef struct packed {
      logic             done;
      logic [TOT_W-1:0] quot_a;
      logic [TOT_W-1:0] quot_b;
   } psw_div_rsp_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_EMIT,
      ST_DIV
   } psw_state_type;

endpackage

FILE: src/psw_ram.sv
`timescale 1ns / 1ps
// generic single write port ram with registered read
module psw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/psw_div.sv
`timescale 1ns / 1ps
// bit-serial restoring divider, two dividends over one shared divisor
module psw_div (
   input  logic                     clock,
   input  logic                     reset,
   input  psw_pkg::psw_div_req_type req,
   output psw_pkg::psw_div_rsp_type rsp
);
   import psw_pkg::*;

   logic [TOT_W-1:0]      num_a_ff, num_a_in;
   logic [TOT_W-1:0]      num_b_ff, num_b_in;
   logic [CNT_W-1:0]      rem_a_ff, rem_a_in;
   logic [CNT_W-1:0]      rem_b_ff, rem_b_in;
   logic [CNT_W-1:0]      den_ff, den_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W:0]        shift_a, shift_b, diff_a, diff_b;

   always_comb begin
      num_a_in = num_a_ff;
      num_b_in = num_b_ff;
      rem_a_in = rem_a_ff;
      rem_b_in = rem_b_ff;
      den_in   = den_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = done_ff;
      shift_a  = {rem_a_ff, num_a_ff[TOT_W-1]};
      shift_b  = {rem_b_ff, num_b_ff[TOT_W-1]};
      diff_a   = shift_a - {1'b0, den_ff};
      diff_b   = shift_b - {1'b0, den_ff};
      if (req.start) begin
         num_a_in = req.dividend_a;
         num_b_in = req.dividend_b;
         rem_a_in = '0;
         rem_b_in = '0;
         den_in   = req.divisor;
         step_in  = '0;
         busy_in  = 1'b1;
         done_in  = 1'b0;
      end else if (busy_ff) begin
         // quotient bits shift in from the bottom as the dividend leaves the top
         if (shift_a >= {1'b0, den_ff}) begin
            rem_a_in = diff_a[CNT_W-1:0];
            num_a_in = {num_a_ff[TOT_W-2:0], 1'b1};
         end else begin
            rem_a_in = shift_a[CNT_W-1:0];
            num_a_in = {num_a_ff[TOT_W-2:0], 1'b0};
         end
         if (shift_b >= {1'b0, den_ff}) begin
            rem_b_in = diff_b[CNT_W-1:0];
            num_b_in = {num_b_ff[TOT_W-2:0], 1'b1};
         end else begin
            rem_b_in = shift_b[CNT_W-1:0];
            num_b_in = {num_b_ff[TOT_W-2:0], 1'b0};
         end
         step_in = step_ff + DIV_STEP_W'(1);
         if (step_ff == DIV_STEP_W'(TOT_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      num_a_ff <= num_a_in;
      num_b_ff <= num_b_in;
      rem_a_ff <= rem_a_in;
      rem_b_ff <= rem_b_in;
      den_ff   <= den_in;
   end

   assign rsp.done   = done_ff;
   assign rsp.quot_a = num_a_ff;
   assign rsp.quot_b = num_b_ff;

endmodule

FILE: src/priority_schedule_wait_times.sv
`timescale 1ns / 1ps
// top level of the non-preemptive priority scheduler
//
// Processes are loaded one per cycle (burst and priority) into a 16 entry store and are
// numbered from one in load order; the transfer flagged last_process closes the set, and a
// transfer arriving with the store full is dropped, though its last flag still closes the set.
// The block then selection-sorts the store by ascending priority, taking the first strict
// minimum among the remaining entries for each position, and hands out one result per process
// in that order with its waiting and turnaround times. The final result carries the truncated
// averages and last_result. Each sorted position walks the remaining entries once through the
// one read port of the store and then passes its result on to the output register; the last
// result instead waits for the bit-serial divider before it is handed over. req_ready is high
// only while loading.
module priority_schedule_wait_times (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  psw_pkg::psw_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output psw_pkg::psw_rsp_type rsp_data
);
   import psw_pkg::*;

   // control
   psw_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;   // fill count while loading, set size after
   logic [CNT_W-1:0] pos_ff, pos_in;       // position being settled
   logic [CNT_W-1:0] scan_ff, scan_in;     // next store address to read
   logic             rd_vld_ff, rd_vld_in;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // datapath
   psw_entry_type    min_ff, min_in;       // best entry found so far
   psw_entry_type    cur_ff, cur_in;       // entry that sat at the position
   logic [IDX_W-1:0] sel_ff, sel_in;
   logic [SUM_W-1:0] wait_ff, wait_in;
   logic [TOT_W-1:0] tot_wait_ff, tot_wait_in;
   logic [TOT_W-1:0] tot_tat_ff, tot_tat_in;
   psw_rsp_type      rsp_data_ff, rsp_data_in;

   // store ports
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   psw_entry_type    wr_data;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   psw_entry_type    rd_data;

   psw_div_req_type  div_req;
   psw_div_rsp_type  div_rsp;

   // helpers
   logic             req_fire;
   logic             store_full;
   logic [EXT_W-1:0] num_ext;
   logic [CNT_W-1:0] n_m1;
   logic             rd_first;
   logic             take_new;
   logic             scan_done;
   logic             last_pos;
   logic             out_free;
   logic [SUM_W-1:0] tat;

   assign req_fire   = req_valid && req_ready;
   assign store_full = (count_ff == CNT_W'(MAX_PROCESSES));
   assign num_ext    = EXT_W'(count_ff) + EXT_W'(1);
   assign n_m1       = count_ff - CNT_W'(1);
   assign rd_first   = (rd_idx_ff == pos_ff);
   assign take_new   = rd_first || (rd_data.prio < min_ff.prio);
   assign scan_done  = (state_ff == ST_SCAN) && rd_vld_ff && (rd_idx_ff == n_m1);
   assign last_pos   = (pos_ff == n_m1);
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign tat        = wait_ff + SUM_W'(min_ff.burst);

   // running minimum over the entries coming back from the store
   always_comb begin
      min_in = min_ff;
      sel_in = sel_ff;
      cur_in = cur_ff;
      if (rd_vld_ff) begin
         if (take_new) begin
            min_in = rd_data;
            sel_in = rd_idx_ff[IDX_W-1:0];
         end
         if (rd_first) begin
            cur_in = rd_data;
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire && req_data.last_process) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (last_pos) begin
               state_in = ST_DIV;
            end else if (out_free) begin
               state_in = ST_SCAN;
            end
         end
         ST_DIV: begin
            if (div_rsp.done && out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // datapath and store control
   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = rd_idx_ff;
      wait_in      = wait_ff;
      tot_wait_in  = tot_wait_ff;
      tot_tat_in   = tot_tat_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = count_ff[IDX_W-1:0];
      wr_data      = '{prio: req_data.priority_level, burst: req_data.burst_time,
                       number: num_ext[NUM_W-1:0]};
      rd_en        = 1'b0;
      rd_addr      = scan_ff[IDX_W-1:0];
      div_req      = '{start: 1'b0, divisor: count_ff, dividend_a: tot_wait_ff,
                       dividend_b: tot_tat_ff};
      unique case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               // a transfer beyond the store is dropped
               if (!store_full) begin
                  wr_en    = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
               if (req_data.last_process) begin
                  pos_in      = '0;
                  scan_in     = '0;
                  wait_in     = '0;
                  tot_wait_in = '0;
                  tot_tat_in  = '0;
               end
            end
         end
         ST_SCAN: begin
            if (scan_ff < count_ff) begin
               rd_en     = 1'b1;
               rd_vld_in = 1'b1;
               rd_idx_in = scan_ff;
               scan_in   = scan_ff + CNT_W'(1);
            end
            // the settled position is never read again, so only the chosen slot
            // takes the displaced entry
            if (scan_done) begin
               wr_en   = 1'b1;
               wr_addr = sel_in;
               wr_data = cur_in;
            end
         end
         ST_EMIT: begin
            rsp_data_in.process_number  = min_ff.number;
            rsp_data_in.burst_out       = min_ff.burst;
            rsp_data_in.waiting_time    = wait_ff[11:0];
            rsp_data_in.turnaround_time = tat[12:0];
            rsp_data_in.average_waiting    = '0;
            rsp_data_in.average_turnaround = '0;
            rsp_data_in.last_result     = 1'b0;
            if (last_pos) begin
               // final totals go straight into the divider, result waits for it
               tot_wait_in        = tot_wait_ff + TOT_W'(wait_ff);
               tot_tat_in         = tot_tat_ff + TOT_W'(tat);
               div_req.start      = 1'b1;
               div_req.dividend_a = tot_wait_in;
               div_req.dividend_b = tot_tat_in;
               rsp_data_in        = rsp_data_ff;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               tot_wait_in  = tot_wait_ff + TOT_W'(wait_ff);
               tot_tat_in   = tot_tat_ff + TOT_W'(tat);
               wait_in      = tat;
               pos_in       = pos_ff + CNT_W'(1);
               scan_in      = pos_ff + CNT_W'(1);
            end else begin
               rsp_data_in = rsp_data_ff;
            end
         end
         ST_DIV: begin
            if (div_rsp.done && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.process_number     = min_ff.number;
               rsp_data_in.burst_out          = min_ff.burst;
               rsp_data_in.waiting_time       = wait_ff[11:0];
               rsp_data_in.turnaround_time    = tat[12:0];
               rsp_data_in.average_waiting    = div_rsp.quot_a[11:0];
               rsp_data_in.average_turnaround = div_rsp.quot_b[12:0];
               rsp_data_in.last_result        = 1'b1;
               count_in = '0;
            end
         end
         default: begin
            rsp_valid_in = rsp_valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         pos_ff       <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      min_ff      <= min_in;
      cur_ff      <= cur_in;
      sel_ff      <= sel_in;
      wait_ff     <= wait_in;
      tot_wait_ff <= tot_wait_in;
      tot_tat_ff  <= tot_tat_in;
      rsp_data_ff <= rsp_data_in;
   end

   // process store: priority, burst and load number side by side
   psw_ram #(
      .WIDTH ($bits(psw_entry_type)),
      .DEPTH (MAX_PROCESSES),
      .AW    (IDX_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // both averages from one serial pass
   psw_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
